[design/sgr_pkg.sv]
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types and constants for the stream group reverser.
// ----------------------------------------------------------------------------
package sgr_pkg;

  // Payload and register widths
  localparam int DATA_W = 32;
  localparam int GS_W   = 5;

  // Default buffer depth (largest group that is reversed)
  localparam int MAX_GROUP_DEF = 16;

  // Configuration register space
  localparam int         PADDR_W          = 3;
  localparam int         PDATA_W          = 32;
  localparam logic [0:0] REG_GROUP_SIZE   = 1'b0;  // word index of group_size
  localparam logic [GS_W-1:0] GROUP_SIZE_RST = 5'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_en;     // store the incoming value
    logic rd_en;     // load one buffered value into the output register
    logic run_last;  // loaded value is the last result of its transaction
    logic list_end;  // loaded value closes the list
  } dp_cmd_t;

  // Controller status seen by the top level
  typedef struct packed {
    logic emitting;  // a group is being drained
  } ctl_sts_t;

endpackage

[design/sgr_datapath.sv]
// ----------------------------------------------------------------------------
// sgr_datapath
// Group buffer memory and output register stage.
// ----------------------------------------------------------------------------
module sgr_datapath
  import sgr_pkg::*;
#(
  parameter int MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dp_cmd_t                      cmd_i,
  input  logic [$clog2(MAX_GROUP)-1:0] wr_addr_i,
  input  logic [$clog2(MAX_GROUP)-1:0] rd_addr_i,
  input  logic [DATA_W-1:0]            wr_data_i,
  output logic                         out_free_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [DATA_W-1:0]            out_data_o,
  output logic                         out_run_last_o,
  output logic                         out_list_end_o
);

  logic [DATA_W-1:0] buf_q [MAX_GROUP];
  logic [DATA_W-1:0] out_data_q;
  logic              out_run_last_q;
  logic              out_list_end_q;
  logic              out_valid_q;

  // Group buffer write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      buf_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read straight into the output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      out_data_q     <= buf_q[rd_addr_i];
      out_run_last_q <= cmd_i.run_last;
      out_list_end_q <= cmd_i.list_end;
    end
  end

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.rd_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_free_o     = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign out_run_last_o = out_run_last_q;
  assign out_list_end_o = out_list_end_q;

endmodule

[design/sgr_ctrl.sv]
// ----------------------------------------------------------------------------
// sgr_ctrl
// Fill/drain sequencer: counts the group, then walks the buffer forward or
// backward to emit it.
// ----------------------------------------------------------------------------
module sgr_ctrl
  import sgr_pkg::*;
#(
  parameter int MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [GS_W-1:0]              group_size_i,
  input  logic                         in_valid_i,
  input  logic                         in_last_i,
  output logic                         in_ready_o,
  input  logic                         out_free_i,
  output dp_cmd_t                      cmd_o,
  output logic [$clog2(MAX_GROUP)-1:0] wr_addr_o,
  output logic [$clog2(MAX_GROUP)-1:0] rd_addr_o,
  output ctl_sts_t                     sts_o
);

  localparam int AW = $clog2(MAX_GROUP);
  localparam int CW = $clog2(MAX_GROUP + 1);

  typedef enum logic {
    ST_FILL,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   fill_q;
  logic [CW-1:0]   cnt_q;    // number of values in the group being drained
  logic [AW-1:0]   idx_q;    // drain position
  logic            rev_q;
  logic            end_q;

  logic [CW-1:0]   grp_eff;
  logic [CW-1:0]   fill_next;
  logic [CW-1:0]   idx_ext;
  logic [CW-1:0]   rev_pos;
  logic            accept;
  logic            drain;
  logic            last_item;

  // Effective group size: 0 and 1 pass through, large values saturate
  always_comb begin
    if (group_size_i == '0) begin
      grp_eff = CW'(1);
    end else if (int'(group_size_i) > MAX_GROUP) begin
      grp_eff = CW'(MAX_GROUP);
    end else begin
      grp_eff = CW'(group_size_i);
    end
  end

  assign accept    = (state_q == ST_FILL) && in_valid_i;
  assign drain     = (state_q == ST_EMIT) && out_free_i;
  assign fill_next = fill_q + CW'(1);
  assign idx_ext   = CW'(idx_q);
  assign rev_pos   = cnt_q - idx_ext - CW'(1);
  assign last_item = (idx_ext + CW'(1)) == cnt_q;

  // Commands to the datapath
  always_comb begin
    cmd_o.wr_en    = accept;
    cmd_o.rd_en    = drain;
    cmd_o.run_last = last_item;
    cmd_o.list_end = last_item && end_q;
  end

  assign wr_addr_o  = fill_q[AW-1:0];
  assign rd_addr_o  = rev_q ? rev_pos[AW-1:0] : idx_q;
  assign in_ready_o = (state_q == ST_FILL);
  assign sts_o.emitting = (state_q == ST_EMIT);

  // Sequencer state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      fill_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      rev_q   <= 1'b0;
      end_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_FILL: begin
          if (accept) begin
            if ((fill_next >= grp_eff) || in_last_i) begin
              cnt_q   <= fill_next;
              rev_q   <= (fill_next >= grp_eff);
              end_q   <= in_last_i;
              idx_q   <= '0;
              fill_q  <= '0;
              state_q <= ST_EMIT;
            end else begin
              fill_q <= fill_next;
            end
          end
        end
        ST_EMIT: begin
          if (drain) begin
            if (last_item) begin
              state_q <= ST_FILL;
            end else begin
              idx_q <= idx_q + AW'(1);
            end
          end
        end
        default: state_q <= ST_FILL;
      endcase
    end
  end

endmodule

[design/stream_group_reverser.sv]
// ----------------------------------------------------------------------------
// stream_group_reverser
// Timing: the transaction that completes a group (or ends the list) sets the
// drain state, then each result is registered into the output stage; the group
// leaves at one value per cycle while the receiver keeps tready high. The
// buffer is either filled or drained, so no input is taken during a drain.
// Reset: asynchronous, active low; empties the buffer count, group_size = 2.
// ----------------------------------------------------------------------------
module stream_group_reverser
  import sgr_pkg::*;
#(
  parameter int MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DATA_W-1:0]  s_axis_tdata,   // [31:0] item_value
  input  logic               s_axis_tlast,   // list_end
  // Output stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [DATA_W-1:0]  m_axis_tdata,   // [31:0] out_value
  output logic [0:0]         m_axis_tuser,   // [0] run_last
  output logic               m_axis_tlast,   // out_list_end
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW = $clog2(MAX_GROUP);

  logic [GS_W-1:0] group_size_q;
  logic            reg_hit;
  dp_cmd_t         cmd;
  ctl_sts_t        sts;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;
  logic            out_free;

  // Register file
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_GROUP_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= GROUP_SIZE_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      group_size_q <= pwdata[GS_W-1:0];
    end
  end

  assign prdata = reg_hit ? PDATA_W'(group_size_q) : '0;

  // Controller
  sgr_ctrl #(
    .MAX_GROUP (MAX_GROUP)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .group_size_i (group_size_q),
    .in_valid_i   (s_axis_tvalid),
    .in_last_i    (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .out_free_i   (out_free),
    .cmd_o        (cmd),
    .wr_addr_o    (wr_addr),
    .rd_addr_o    (rd_addr),
    .sts_o        (sts)
  );

  // Datapath
  sgr_datapath #(
    .MAX_GROUP (MAX_GROUP)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .wr_addr_i      (wr_addr),
    .rd_addr_i      (rd_addr),
    .wr_data_i      (s_axis_tdata),
    .out_free_o     (out_free),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata),
    .out_run_last_o (m_axis_tuser[0]),
    .out_list_end_o (m_axis_tlast)
  );

  // Checks
  a_end_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> sts.emitting)
    else $error("list end did not start a drain");

  a_no_accept_while_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.emitting |-> !s_axis_tready)
    else $error("input accepted while draining");

  a_list_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("list end without run end");

endmodule

[tb/sv/tb_stream_group_reverser.sv]
// ----------------------------------------------------------------------------
// tb_stream_group_reverser
// Self-checking bench for the stream group reverser. A short table of
// directed lists (reset group size, pass-through, oversized and lowered group
// sizes) is followed by random lists under several idle patterns on both
// stream sides. Every input transaction is run through a local prediction of
// the reordering, and each output transaction is checked against the oldest
// expected result.
// ----------------------------------------------------------------------------
module tb_stream_group_reverser;
  import sgr_pkg::*;

  localparam int MAX_GROUP    = MAX_GROUP_DEF;
  localparam int WATCHDOG_MAX = 3000;  // cycles without any transaction
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int DRAIN_WAIT   = 4;     // settle time before a register write
  localparam int TAIL_WAIT    = 40;
  localparam int PHASE_ITEMS  = 50;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

  // One output transaction: value, last of its input, last of the list
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              run_last;
    logic              list_end;
  } reordered_t;

  // Directed stimulus row; exp is only used where typed is set
  typedef struct packed {
    logic [GS_W-1:0]   gsize;
    logic [DATA_W-1:0] value;
    logic              last;
    logic              typed;
    reordered_t        exp;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [DATA_W-1:0]  s_axis_tdata = '0;  // [31:0] item_value
  logic               s_axis_tlast = 1'b0;  // list_end
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [DATA_W-1:0]  m_axis_tdata;  // [31:0] out_value
  logic [0:0]         m_axis_tuser;  // [0] run_last
  logic               m_axis_tlast;  // out_list_end
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Prediction state
  logic [DATA_W-1:0]  grp_buf [MAX_GROUP];
  int unsigned        held_cnt = 0;
  logic [GS_W-1:0]    gsize_cfg = GROUP_SIZE_RST;
  reordered_t         reordered_q [$];

  idle_mode_e         idle_mode = IDLE_NONE;
  int                 src_idle_pct = 0;
  int                 snk_idle_pct = 0;
  logic               hold_req = 1'b0;
  logic               hold_done = 1'b0;
  int                 hold_left = 0;
  int                 mismatch_cnt = 0;
  int                 stall_cycles = 0;

  dir_row_t dir_table [21] = '{
    '{5'd2,  32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{5'd2,  32'h8000_0000, 1'b0, 1'b0, '0},
    '{5'd2,  32'h1234_5678, 1'b1, 1'b1, {32'h1234_5678, 1'b1, 1'b1}},
    '{5'd1,  32'h0000_0000, 1'b0, 1'b1, {32'h0000_0000, 1'b1, 1'b0}},
    '{5'd1,  32'hFFFF_FFFF, 1'b1, 1'b1, {32'hFFFF_FFFF, 1'b1, 1'b1}},
    '{5'd0,  32'hA5A5_A5A5, 1'b0, 1'b1, {32'hA5A5_A5A5, 1'b1, 1'b0}},
    '{5'd0,  32'h5A5A_5A5A, 1'b1, 1'b1, {32'h5A5A_5A5A, 1'b1, 1'b1}},
    // full group closing the list
    '{5'd3,  32'h0000_0001, 1'b0, 1'b0, '0},
    '{5'd3,  32'h0000_0002, 1'b0, 1'b0, '0},
    '{5'd3,  32'h0000_0003, 1'b1, 1'b0, '0},
    // group size lowered while three values are held
    '{5'd5,  32'h0000_0010, 1'b0, 1'b0, '0},
    '{5'd5,  32'h0000_0011, 1'b0, 1'b0, '0},
    '{5'd5,  32'h0000_0012, 1'b0, 1'b0, '0},
    '{5'd2,  32'h0000_0013, 1'b0, 1'b0, '0},
    '{5'd2,  32'h0000_0014, 1'b1, 1'b1, {32'h0000_0014, 1'b1, 1'b1}},
    // oversized settings act as the buffer depth
    '{5'd31, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{5'd31, 32'h8000_0001, 1'b1, 1'b0, '0},
    '{5'd31, 32'hDEAD_BEEF, 1'b1, 1'b1, {32'hDEAD_BEEF, 1'b1, 1'b1}},
    '{5'd17, 32'h7FFF_FFFE, 1'b0, 1'b0, '0},
    '{5'd17, 32'h0000_0001, 1'b1, 1'b0, '0},
    '{5'd16, 32'hCAFE_F00D, 1'b1, 1'b1, {32'hCAFE_F00D, 1'b1, 1'b1}}
  };

  stream_group_reverser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  // Buffer one value; emit the held values once the group is complete
  // (reversed) or the list ends (original order).
  task automatic reorder_predict(input logic [DATA_W-1:0] v, input logic last);
    int unsigned eff;
    int unsigned n;
    int unsigned src;
    bit          rev;
    reordered_t  r;
    eff = gsize_cfg;
    if (eff < 1) eff = 1;
    if (eff > MAX_GROUP) eff = MAX_GROUP;
    if (held_cnt >= MAX_GROUP) held_cnt = MAX_GROUP - 1;
    grp_buf[held_cnt] = v;
    held_cnt++;
    if (held_cnt >= eff) rev = 1'b1;
    else if (last) rev = 1'b0;
    else return;
    n = held_cnt;
    for (int unsigned i = 0; i < n; i++) begin
      src        = rev ? (n - 1 - i) : i;
      r.value    = grp_buf[src];
      r.run_last = (i + 1 == n);
      r.list_end = (i + 1 == n) && last;
      reordered_q.push_back(r);
    end
    held_cnt = 0;
  endtask

  function automatic bit pick_idle(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Offer one input transaction; predict once it is accepted
  task automatic send_item(input logic [DATA_W-1:0] v, input logic last,
                           input logic typed, input reordered_t exp);
    @(negedge clk_i);
    while (pick_idle(src_idle_pct)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    reorder_predict(v, last);
    if (typed) reordered_q[reordered_q.size() - 1] = exp;
  endtask

  // Stop offering and wait until every expected result is out
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (reordered_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_group_size(input logic [GS_W-1:0] gs);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(REG_GROUP_SIZE) << 2;
    pwdata  <= PDATA_W'(gs);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    gsize_cfg = gs;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random well-formed lists, each under a fresh group size
  task automatic send_random_lists(input int n_items);
    int              sent;
    int              len;
    int              sel;
    logic [GS_W-1:0] gs;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: gs = 5'd0;
        1: gs = 5'd1;
        2: gs = 5'd16;
        3: gs = GS_W'($urandom_range(17, 31));
        default: gs = GS_W'($urandom_range(2, 6));
      endcase
      wait_drained();
      write_group_size(gs);
      if (gs >= 5'd16) len = $urandom_range(10, 36);
      else len = $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
        send_item($urandom, (i == len - 1), 1'b0, '0);
      end
      sent += len;
    end
  endtask

  function automatic void set_idle(input idle_mode_e m);
    idle_mode    = m;
    src_idle_pct = (m == IDLE_SRC) ? 84 : (m == IDLE_BOTH) ? 29 : 0;
    snk_idle_pct = (m == IDLE_SNK) ? 84 : (m == IDLE_BOTH) ? 29 : 0;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !pick_idle(snk_idle_pct);
    end
  end

  // Output check against the oldest expectation
  always @(posedge clk_i) begin
    reordered_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reordered_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected output: value %h run_last %b list_end %b",
                   m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
      end else begin
        exp_r = reordered_q.pop_front();
        if (m_axis_tdata !== exp_r.value || m_axis_tuser[0] !== exp_r.run_last ||
            m_axis_tlast !== exp_r.list_end) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch: exp %h/%b/%b got %h/%b/%b (value/run_last/list_end)",
                     exp_r.value, exp_r.run_last, exp_r.list_end,
                     m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_MAX) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [GS_W-1:0] cur_gs;
    set_idle(IDLE_NONE);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, starting from the reset group size
    cur_gs = GROUP_SIZE_RST;
    foreach (dir_table[k]) begin
      if (dir_table[k].gsize != cur_gs) begin
        wait_drained();
        write_group_size(dir_table[k].gsize);
        cur_gs = dir_table[k].gsize;
      end
      send_item(dir_table[k].value, dir_table[k].last, dir_table[k].typed,
                dir_table[k].exp);
    end

    // Random lists; the first phase also fills the block behind a held receiver
    wait_drained();
    hold_req = 1'b1;
    send_random_lists(PHASE_ITEMS);
    set_idle(IDLE_SRC);
    send_random_lists(PHASE_ITEMS);
    set_idle(IDLE_SNK);
    send_random_lists(PHASE_ITEMS);
    set_idle(IDLE_BOTH);
    send_random_lists(PHASE_ITEMS);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (reordered_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (reordered_q.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[stream_group_reverser.f]
design/sgr_pkg.sv
design/sgr_datapath.sv
design/sgr_ctrl.sv
design/stream_group_reverser.sv
tb/sv/tb_stream_group_reverser.sv
